[hw/rtl/dfr_pkg.sv]
package dfr_pkg;

  // Tach-to-rpm numerator and its width
  localparam int unsigned TACH_NUM_W = 22;
  localparam logic [TACH_NUM_W-1:0] TACH_NUM = 22'd2156250;
  localparam int unsigned CNT_W = 5;

  localparam int unsigned TACH_W  = 16;
  localparam int unsigned RPM_W   = 16;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned DBAND_W = 12;
  localparam int unsigned DTGT_W  = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DTGT_W-1:0] DBG_LIMIT = 8'd40;
  localparam logic [RPM_W-1:0]  DBG_SCALE = 16'd100;

  localparam logic [DBAND_W-1:0] DBAND_RST    = 12'd100;
  localparam logic [DUTY_W-1:0]  MAX_DUTY_RST = 8'd200;
  localparam logic [RPM_W-1:0]   MAX_RPM_RST  = 16'd6000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBUG_MODE   = 3'd0,
    CFG_DEBUG_TARGET = 3'd1,
    CFG_DEADBAND     = 3'd2,
    CFG_MAX_DUTY     = 3'd3,
    CFG_MAX_RPM      = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_B,
    ST_STEP_A,
    ST_STEP_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[hw/rtl/dfr_div.sv]
// Restoring divider, constant tach numerator over a 16-bit count, one bit per cycle.
module dfr_div
  import dfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [TACH_W-1:0]     divisor,
  output div_stat_t             stat,
  output logic [TACH_NUM_W-1:0] quotient
);

  logic [TACH_W-1:0]     rem_r, rem_nxt;
  logic [TACH_NUM_W-1:0] q_r, q_nxt;
  logic [TACH_W-1:0]     dvs_r, dvs_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic [TACH_W:0]       rem_sh;
  logic                  fits;

  assign rem_sh = {rem_r, q_r[TACH_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      q_nxt    = TACH_NUM;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? TACH_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[TACH_W-1:0];
      q_nxt   = {q_r[TACH_NUM_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(TACH_NUM_W - 1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  // done marks the cycle after the last quotient bit lands
  logic busy_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) busy_d_r <= 1'b0;
    else        busy_d_r <= busy_r;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_d_r && !busy_r;
  assign quotient  = q_r;

endmodule

[hw/rtl/dfr_step.sv]
// One duty step toward the goal, deadband compare at widened width.
module dfr_step
  import dfr_pkg::*;
(
  input  logic [DUTY_W-1:0]  duty,
  input  logic [RPM_W-1:0]   goal,
  input  logic [RPM_W-1:0]   speed,
  input  logic [DBAND_W-1:0] deadband,
  input  logic [DUTY_W-1:0]  max_duty,
  input  logic               clamp_high,
  output logic [DUTY_W-1:0]  duty_new
);

  logic [RPM_W+1:0] goal_w, speed_w, db_w;
  logic             up_req, dn_req;

  assign goal_w  = {2'b00, goal};
  assign speed_w = {2'b00, speed};
  assign db_w    = (RPM_W+2)'(deadband);

  // goal - db > speed  and  goal + db < speed, without wrap
  assign up_req = goal_w > (speed_w + db_w);
  assign dn_req = (goal_w + db_w) < speed_w;

  always_comb begin
    duty_new = duty;
    priority if (up_req) begin
      if (duty < max_duty)  duty_new = duty + 1'b1;
      else if (clamp_high)  duty_new = max_duty;
    end else if (dn_req) begin
      if (duty != '0) duty_new = duty - 1'b1;
    end
  end

endmodule

[hw/rtl/dual_fan_rpm_duty_regulator_unit.sv]
// Channel | Ports                                         | Direction
// --------+-----------------------------------------------+----------
// in      | in_valid/in_ready, tach counts, goal speeds   | in
// out     | out_valid/out_ready, duties, speeds           | out
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data      | in
//
// A tick is accepted, runs fan A then fan B through the shared radix-2
// divider (one quotient bit per cycle, 22-bit numerator), takes 2 steps
// through the shared duty stepper and loads the output register. Ticks with
// both goals zero in normal mode skip the divider and the stepper.
// Reset (sync, active low) clears speeds, duties and the output valid and
// loads register defaults. A stalled output beat holds the sequencer in
// ST_DONE; in_ready is high only in ST_IDLE. cfg_ready is always high.
module dual_fan_rpm_duty_regulator_unit
  import dfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [TACH_W-1:0]     in_tach_count_a,
  input  logic [TACH_W-1:0]     in_tach_count_b,
  input  logic [RPM_W-1:0]      in_goal_rpm_a,
  input  logic [RPM_W-1:0]      in_goal_rpm_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_W-1:0]     out_duty_a,
  output logic [DUTY_W-1:0]     out_duty_b,
  output logic [RPM_W-1:0]      out_speed_a,
  output logic [RPM_W-1:0]      out_speed_b,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic               dbg_mode_r;
  logic [DTGT_W-1:0]  dbg_tgt_r;
  logic [DBAND_W-1:0] dband_r;
  logic [DUTY_W-1:0]  max_duty_r;
  logic [RPM_W-1:0]   max_rpm_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbg_mode_r <= 1'b0;
      dbg_tgt_r  <= '0;
      dband_r    <= DBAND_RST;
      max_duty_r <= MAX_DUTY_RST;
      max_rpm_r  <= MAX_RPM_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBUG_MODE:   dbg_mode_r <= cfg_data[0];
        CFG_DEBUG_TARGET: dbg_tgt_r  <= cfg_data[DTGT_W-1:0];
        CFG_DEADBAND:     dband_r    <= cfg_data[DBAND_W-1:0];
        CFG_MAX_DUTY:     max_duty_r <= cfg_data[DUTY_W-1:0];
        CFG_MAX_RPM:      max_rpm_r  <= cfg_data[RPM_W-1:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  // debug goal: min(target, 40) * 100
  logic [DTGT_W-1:0] dbg_clip;
  logic [RPM_W-1:0]  dbg_goal;
  assign dbg_clip = (dbg_tgt_r > DBG_LIMIT) ? DBG_LIMIT : dbg_tgt_r;
  assign dbg_goal = RPM_W'(dbg_clip) * DBG_SCALE;

  // state and per-tick operands
  state_t            state_r, state_nxt;
  logic [TACH_W-1:0] tach_a_r, tach_a_nxt, tach_b_r, tach_b_nxt;
  logic [RPM_W-1:0]  goal_a_r, goal_a_nxt, goal_b_r, goal_b_nxt;
  logic [RPM_W-1:0]  spd_a_r, spd_a_nxt, spd_b_r, spd_b_nxt;
  logic [DUTY_W-1:0] duty_a_r, duty_a_nxt, duty_b_r, duty_b_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              load_out;

  // shared divider
  logic                  div_start;
  logic [TACH_W-1:0]     div_dvs;
  div_stat_t             div_stat;
  logic [TACH_NUM_W-1:0] div_q;

  dfr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // clamp the quotient; a stopped fan reads zero
  logic [TACH_W-1:0] div_cnt;
  logic [RPM_W-1:0]  spd_clamped;
  assign div_cnt = (state_r == ST_DIV_A) ? tach_a_r : tach_b_r;
  always_comb begin
    if (div_cnt == '0)                                   spd_clamped = '0;
    else if (div_q > TACH_NUM_W'(max_rpm_r))             spd_clamped = max_rpm_r;
    else                                                 spd_clamped = div_q[RPM_W-1:0];
  end

  // shared duty stepper, fan A then fan B
  logic              sel_b;
  logic [DUTY_W-1:0] step_out;
  assign sel_b = (state_r == ST_STEP_B);

  dfr_step u_step (
    .duty       (sel_b ? duty_b_r : duty_a_r),
    .goal       (sel_b ? goal_b_r : goal_a_r),
    .speed      (sel_b ? spd_b_r  : spd_a_r),
    .deadband   (dband_r),
    .max_duty   (max_duty_r),
    .clamp_high (!dbg_mode_r),
    .duty_new   (step_out)
  );

  logic dbg_zero;
  assign dbg_zero = dbg_mode_r && (dbg_tgt_r == '0);

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    tach_a_nxt    = tach_a_r;
    tach_b_nxt    = tach_b_r;
    goal_a_nxt    = goal_a_r;
    goal_b_nxt    = goal_b_r;
    spd_a_nxt     = spd_a_r;
    spd_b_nxt     = spd_b_r;
    duty_a_nxt    = duty_a_r;
    duty_b_nxt    = duty_b_r;
    out_valid_nxt = out_valid_r && !out_ready;
    load_out      = 1'b0;
    div_start     = 1'b0;
    div_dvs       = in_tach_count_a;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          tach_a_nxt = in_tach_count_a;
          tach_b_nxt = in_tach_count_b;
          goal_a_nxt = dbg_mode_r ? dbg_goal : in_goal_rpm_a;
          goal_b_nxt = dbg_mode_r ? dbg_goal : in_goal_rpm_b;
          if (!dbg_mode_r && in_goal_rpm_a == '0 && in_goal_rpm_b == '0) begin
            // both goals off: clear any running fan, skip measurement
            if (duty_a_r != '0) begin
              duty_a_nxt = '0;
              spd_a_nxt  = '0;
            end
            if (duty_b_r != '0) begin
              duty_b_nxt = '0;
              spd_b_nxt  = '0;
            end
            state_nxt = ST_DONE;
          end else begin
            div_start = 1'b1;
            state_nxt = ST_DIV_A;
          end
        end
      end
      ST_DIV_A: begin
        div_dvs = tach_b_r;
        if (div_stat.done) begin
          spd_a_nxt = spd_clamped;
          div_start = 1'b1;
          state_nxt = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        div_dvs = tach_b_r;
        if (div_stat.done) begin
          spd_b_nxt = spd_clamped;
          state_nxt = ST_STEP_A;
        end
      end
      ST_STEP_A: begin
        duty_a_nxt = dbg_zero ? '0 : step_out;
        state_nxt  = ST_STEP_B;
      end
      ST_STEP_B: begin
        duty_b_nxt = dbg_zero ? '0 : step_out;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      spd_a_r     <= '0;
      spd_b_r     <= '0;
      duty_a_r    <= '0;
      duty_b_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      spd_a_r     <= spd_a_nxt;
      spd_b_r     <= spd_b_nxt;
      duty_a_r    <= duty_a_nxt;
      duty_b_r    <= duty_b_nxt;
    end
    tach_a_r <= tach_a_nxt;
    tach_b_r <= tach_b_nxt;
    goal_a_r <= goal_a_nxt;
    goal_b_r <= goal_b_nxt;
  end

  // output beat register
  logic [DUTY_W-1:0] o_duty_a_r, o_duty_b_r;
  logic [RPM_W-1:0]  o_spd_a_r, o_spd_b_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_duty_a_r <= duty_a_r;
      o_duty_b_r <= duty_b_r;
      o_spd_a_r  <= spd_a_r;
      o_spd_b_r  <= spd_b_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_duty_a  = o_duty_a_r;
  assign out_duty_b  = o_duty_b_r;
  assign out_speed_a = o_spd_a_r;
  assign out_speed_b = o_spd_b_r;

endmodule

[sim/tb.sv]
module tb
  import dfr_pkg::*;
();

  // Tach period count to rpm: rpm = RPM_PER_COUNT / count
  localparam int unsigned RPM_PER_COUNT = 2156250;
  // Debug target is in hundreds of rpm and saturates at 40 hundreds
  localparam int unsigned DBG_CAP       = 40;
  localparam int unsigned DBG_STEP_RPM  = 100;

  // Quiet cycles allowed before the run is declared hung. Worst honest quiet
  // stretch is the long receiver hold-off plus one tick plus both idle
  // bursts, so this leaves plenty of margin.
  localparam int unsigned QUIET_LIMIT     = 3000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned TAIL_CYCLES     = 80;
  localparam int unsigned RAND_PHASES     = 10;
  localparam int unsigned TICKS_PER_PHASE = 53;
  // First register index past the defined set; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_IDX_W'(CFG_MAX_RPM + 1);

  typedef struct {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic [RPM_W-1:0]  speed_a;
    logic [RPM_W-1:0]  speed_b;
  } fan_beat_t;

  // Tracks the regulator's registers and per-fan state, and keeps the
  // result beats still owed by the block in order of their ticks.
  class fan_regulator_scoreboard;
    bit                 dbg_on;
    logic [DTGT_W-1:0]  dbg_target;
    logic [DBAND_W-1:0] deadband;
    logic [DUTY_W-1:0]  duty_cap;
    logic [RPM_W-1:0]   rpm_cap;
    logic [RPM_W-1:0]   speed_a;
    logic [RPM_W-1:0]   speed_b;
    logic [DUTY_W-1:0]  duty_a;
    logic [DUTY_W-1:0]  duty_b;
    fan_beat_t          owed_beats[$];
    int                 mismatches;

    function new();
      dbg_on     = 1'b0;
      dbg_target = '0;
      deadband   = DBAND_RST;
      duty_cap   = MAX_DUTY_RST;
      rpm_cap    = MAX_RPM_RST;
      speed_a    = '0;
      speed_b    = '0;
      duty_a     = '0;
      duty_b     = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DEBUG_MODE:   dbg_on     = data[0];
        CFG_DEBUG_TARGET: dbg_target = data[DTGT_W-1:0];
        CFG_DEADBAND:     deadband   = data[DBAND_W-1:0];
        CFG_MAX_DUTY:     duty_cap   = data[DUTY_W-1:0];
        CFG_MAX_RPM:      rpm_cap    = data[RPM_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [RPM_W-1:0] rpm_from_count(logic [TACH_W-1:0] count);
      int unsigned q;
      if (count == '0) return '0;
      q = RPM_PER_COUNT / count;
      if (q > rpm_cap) q = rpm_cap;
      return RPM_W'(q);
    endfunction

    // One duty step; band edges are signed so goal - deadband may go negative
    function logic [DUTY_W-1:0] nudge(logic [DUTY_W-1:0] duty, int goal,
                                      logic [RPM_W-1:0] speed, bit pin_to_cap);
      int lo;
      int hi;
      lo = goal - int'(deadband);
      hi = goal + int'(deadband);
      if (lo > int'(speed)) begin
        if (duty < duty_cap) duty = duty + 1'b1;
        else if (pin_to_cap) duty = duty_cap;
      end else if (hi < int'(speed)) begin
        if (duty != '0) duty = duty - 1'b1;
      end
      return duty;
    endfunction

    function void note_tick(logic [TACH_W-1:0] tach_a, logic [TACH_W-1:0] tach_b,
                            logic [RPM_W-1:0] goal_a, logic [RPM_W-1:0] goal_b);
      fan_beat_t beat;
      int        dbg_rpm;
      if (!dbg_on) begin
        if (goal_a != '0 || goal_b != '0) begin
          speed_a = rpm_from_count(tach_a);
          speed_b = rpm_from_count(tach_b);
          duty_a  = nudge(duty_a, int'(goal_a), speed_a, 1'b1);
          duty_b  = nudge(duty_b, int'(goal_b), speed_b, 1'b1);
        end else begin
          // both goals off: only a running fan is cleared
          if (duty_a != '0) begin
            speed_a = '0;
            duty_a  = '0;
          end
          if (duty_b != '0) begin
            speed_b = '0;
            duty_b  = '0;
          end
        end
      end else begin
        speed_a = rpm_from_count(tach_a);
        speed_b = rpm_from_count(tach_b);
        if (dbg_target == '0) begin
          duty_a = '0;
          duty_b = '0;
        end else begin
          dbg_rpm = (dbg_target > DBG_CAP) ? DBG_CAP : int'(dbg_target);
          dbg_rpm = dbg_rpm * DBG_STEP_RPM;
          duty_a  = nudge(duty_a, dbg_rpm, speed_a, 1'b0);
          duty_b  = nudge(duty_b, dbg_rpm, speed_b, 1'b0);
        end
      end
      beat.duty_a  = duty_a;
      beat.duty_b  = duty_b;
      beat.speed_a = speed_a;
      beat.speed_b = speed_b;
      owed_beats.push_back(beat);
    endfunction

    function void match(string field, logic [RPM_W-1:0] want, logic [RPM_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_beat(logic [DUTY_W-1:0] got_duty_a, logic [DUTY_W-1:0] got_duty_b,
                             logic [RPM_W-1:0] got_speed_a, logic [RPM_W-1:0] got_speed_b);
      fan_beat_t want;
      if (owed_beats.size() == 0) begin
        $error("result beat with no tick outstanding");
        mismatches++;
        return;
      end
      want = owed_beats.pop_front();
      match("duty_a", want.duty_a, got_duty_a);
      match("duty_b", want.duty_b, got_duty_b);
      match("speed_a", want.speed_a, got_speed_a);
      match("speed_b", want.speed_b, got_speed_b);
    endfunction

    function int outstanding();
      return owed_beats.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [TACH_W-1:0]     in_tach_count_a = '0;
  logic [TACH_W-1:0]     in_tach_count_b = '0;
  logic [RPM_W-1:0]      in_goal_rpm_a = '0;
  logic [RPM_W-1:0]      in_goal_rpm_b = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [DUTY_W-1:0]     out_duty_a;
  logic [DUTY_W-1:0]     out_duty_b;
  logic [RPM_W-1:0]      out_speed_a;
  logic [RPM_W-1:0]      out_speed_b;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // calm: no idling on either side (last part of the run)
  bit          calm = 1'b0;
  // each increment asks the receiver for one long hold-off
  int unsigned hold_tokens = 0;
  int unsigned quiet_cycles = 0;

  fan_regulator_scoreboard fan_sb = new();

  dual_fan_rpm_duty_regulator_unit u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Monitor: everything is sampled at the rising edge, before any of this
  // edge's updates land. An output beat is checked before a same-edge input
  // is noted, since a beat can never belong to a tick accepted with it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) fan_sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready)
        fan_sb.check_beat(out_duty_a, out_duty_b, out_speed_a, out_speed_b);
      if (in_valid && in_ready)
        fan_sb.note_tick(in_tach_count_a, in_tach_count_b, in_goal_rpm_a, in_goal_rpm_b);
    end
  end

  // Watchdog: any accepted beat on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver: random ready bursts, a long hold-off on request, and steady
  // ready once the run goes calm. One assignment per edge at most.
  initial begin : receiver
    int unsigned holds_seen;
    int unsigned span;
    logic        level;
    holds_seen = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_tokens != holds_seen) begin
        holds_seen++;
        level = 1'b0;
        span  = HOLD_CYCLES;
      end else if (calm) begin
        level = 1'b1;
        span  = 1;
      end else if ($urandom_range(0, 3) == 0) begin
        level = 1'b0;
        span  = $urandom_range(1, 18);
      end else begin
        level = 1'b1;
        span  = $urandom_range(1, 40);
      end
      out_ready <= level;
      repeat (span) @(posedge clk);
    end
  end

  // Offer one tick beat and wait for it to be taken. Valid is left high on
  // return so a back-to-back beat just swaps the payload.
  task automatic send_tick(input logic [TACH_W-1:0] ta, input logic [TACH_W-1:0] tbb,
                           input logic [RPM_W-1:0] ga, input logic [RPM_W-1:0] gb);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_tach_count_a <= ta;
    in_tach_count_b <= tbb;
    in_goal_rpm_a   <= ga;
    in_goal_rpm_b   <= gb;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Stop offering and wait for every owed beat. The first edge lets the
  // monitor note a tick accepted at the edge we were called on.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (fan_sb.outstanding() != 0);
  endtask

  // One register write beat; bits above the field width get junk, which the
  // block must drop.
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value,
                         input int unsigned width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    if (width < CFG_DATA_W) value = value | (junk << width);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  // Registers change only with the block idle; every one is rewritten, plus
  // a write to an unused index.
  task automatic apply_config(input bit dm, input int unsigned dt, input int unsigned db,
                              input int unsigned md, input int unsigned mr);
    drain_results();
    put_reg(CFG_DEBUG_MODE, CFG_DATA_W'(dm), 1);
    put_reg(CFG_DEBUG_TARGET, CFG_DATA_W'(dt), DTGT_W);
    put_reg(CFG_DEADBAND, CFG_DATA_W'(db), DBAND_W);
    put_reg(CFG_MAX_DUTY, CFG_DATA_W'(md), DUTY_W);
    put_reg(CFG_MAX_RPM, CFG_DATA_W'(mr), RPM_W);
    put_reg(CFG_IDX_W'(CFG_SPARE_FIRST + $urandom_range(0, 2)), CFG_DATA_W'($urandom),
            CFG_DATA_W);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [TACH_W-1:0] pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 20) return TACH_W'($urandom);
    if (r < 35) return TACH_W'($urandom_range(1, 400));
    // 300..3000 counts spans roughly 700..7200 rpm, around most goals
    return TACH_W'($urandom_range(300, 3000));
  endfunction

  // Goals are mostly placed near the fan's speed so that both band edges
  // and the hold zone get hit.
  function automatic logic [RPM_W-1:0] pick_goal(logic [TACH_W-1:0] count);
    int unsigned r;
    int          centre;
    int          band;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 25) return RPM_W'($urandom);
    if (r < 45) return RPM_W'($urandom_range(0, 7000));
    centre = (count == '0) ? 0 : int'(RPM_PER_COUNT / count);
    band   = int'(fan_sb.deadband) + 40;
    centre = centre + int'($urandom_range(0, 2 * band)) - band;
    if (centre < 0) return '0;
    if (centre > 65535) return '1;
    return RPM_W'(centre);
  endfunction

  initial begin : stimulus
    int unsigned        r;
    int unsigned        dt;
    int unsigned        db;
    int unsigned        md;
    int unsigned        mr;
    logic [TACH_W-1:0]  ta;
    logic [TACH_W-1:0]  tbb;
    logic [RPM_W-1:0]   ga;
    logic [RPM_W-1:0]   gb;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part, register defaults first ---
    send_tick('0, '0, '0, '0);                   // both goals off, duties already 0
    send_tick('1, 1, '1, '1);                    // slowest count; count 1 clamps
    send_tick(359, 431, 6500, 5000);             // just over max_rpm; b in band
    send_tick(1078, 2156, 1000, 100);            // both above band: step down
    send_tick('0, '0, 50, 0);                    // goal - band below zero, stopped fan
    send_tick(1000, 1000, '1, '0);               // b steps down from 0: stays 0
    send_tick('0, '0, '0, '0);                   // a cleared, b keeps its held speed

    // zero deadband, widest duty and rpm limits
    apply_config(1'b0, 0, 0, 255, 65535);
    send_tick(1, '1, '1, 33);                    // quotient past 16 bits clamps
    send_tick(2, 3, 1, '1);
    repeat (4) send_tick('1, '1, '1, '1);        // push both duties up

    // duty now above the cap, widest band, rpm ceiling 0
    apply_config(1'b0, 0, 4095, 1, 0);
    send_tick('1, '1, '1, '1);                   // increase request pins to cap
    send_tick(100, 100, 4095, 4096);             // lower edge exactly at speed
    apply_config(1'b0, 0, 100, 0, 6000);
    send_tick(1, 1, '1, '1);                     // cap 0

    // debug mode
    apply_config(1'b1, 0, 100, 200, 6000);
    send_tick(1000, '0, 123, '0);                // target 0 forces duties off
    apply_config(1'b1, 255, 100, 200, 6000);
    send_tick('1, 539, '0, '0);                  // target clamps to 4000
    repeat (3) send_tick('1, '1, '0, '0);
    apply_config(1'b1, 41, 100, 2, 6000);        // duty above cap in debug
    send_tick('1, '1, '0, '0);                   // increase request holds duty
    send_tick(359, 359, '0, '0);                 // fast fans step down

    // --- random phases, one register setting each ---
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      r  = $urandom_range(0, 99);
      dt = (r < 15) ? 0 : (r < 60) ? $urandom_range(1, 40) : $urandom_range(41, 255);
      r  = $urandom_range(0, 99);
      db = (r < 15) ? 0 : (r < 25) ? 4095 : (r < 30) ? $urandom_range(0, 4095)
                                                      : $urandom_range(1, 300);
      r  = $urandom_range(0, 99);
      md = (r < 10) ? 0 : (r < 20) ? 255 : (r < 50) ? $urandom_range(1, 12)
                                                     : $urandom_range(0, 255);
      r  = $urandom_range(0, 99);
      mr = (r < 10) ? 0 : (r < 20) ? 65535 : (r < 40) ? 6000 : $urandom_range(0, 65535);
      apply_config(ph % 3 == 1, dt, db, md, mr);
      if (ph == RAND_PHASES - 1) calm = 1'b1;

      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        // long receiver stall while ticks keep coming: input backs up
        if (ph == 2 && n == 10) hold_tokens <= hold_tokens + 1;
        // sender pause until the block has nothing left to deliver
        if (ph == 5 && n == 25) drain_results();
        ta  = pick_count();
        tbb = pick_count();
        ga  = pick_goal(ta);
        gb  = pick_goal(tbb);
        if ($urandom_range(0, 11) == 0) begin
          ga = '0;
          gb = '0;
        end
        send_tick(ta, tbb, ga, gb);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fan_sb.mismatches == 0 && fan_sb.outstanding() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
